// ===== rtl/mrfc_pkg.sv =====
// shared types and constants for the muller cubic root finder
package mrfc_pkg;

  localparam int FRAC_BITS_DEF = 20;
  localparam int ITER_W = 8;
  localparam int TOL_W = 31;

  localparam logic [TOL_W-1:0] STEP_TOL_RESET = 31'd105;
  localparam logic [ITER_W-1:0] ITER_LIMIT_RESET = 8'd50;
  localparam logic [ITER_W-1:0] ITER_START = 8'd3;

  // register indexes
  localparam logic [0:0] REG_STEP_TOL = 1'b0;
  localparam logic [0:0] REG_ITER_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    OUT_CONVERGED = 2'd0,
    OUT_LIMIT     = 2'd1,
    OUT_NEG_DISC  = 2'd2,
    OUT_FAULT     = 2'd3
  } outcome_t;

  // arithmetic unit operations
  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } alu_op_t;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE,
    // cubic of an operand: x2 = x*x, x3 = x2*x, combine
    S_CUB_X2, S_CUB_X3, S_CUB_SUM,
    // setup and refit steps
    S_F0, S_F1, S_F2,
    S_H, S_Q1, S_Q2, S_D,
    // iteration
    S_IT_HD, S_IT_B, S_IT_BB, S_IT_FD, S_IT_DISC,
    S_IT_SQRT, S_IT_E, S_IT_STEP, S_IT_CHECK,
    S_WAIT_ALU,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                    start;
    alu_op_t                 op;
    logic signed [63:0]      a;
    logic signed [63:0]      b;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    logic               fault;
    logic signed [63:0] res;
  } alu_rsp_t;

  function automatic logic fits32(input logic signed [63:0] v);
    return (v <= 64'sd2147483647) && (v >= -64'sd2147483648);
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? (64'd0 - 64'(v)) : 64'(v);
  endfunction

endpackage

// ===== rtl/mrfc_if.sv =====
// valid/ready channel interfaces for item and configuration traffic
interface mrfc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] guess_a;
  logic signed [31:0] guess_b;
  logic signed [31:0] guess_c;
  modport source (output valid, guess_a, guess_b, guess_c, input ready);
  modport sink (input valid, guess_a, guess_b, guess_c, output ready);
endinterface

interface mrfc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] root_value;
  logic [7:0]         iterations_used;
  logic [1:0]         outcome;
  modport source (output valid, root_value, iterations_used, outcome, input ready);
  modport sink (input valid, root_value, iterations_used, outcome, output ready);
endinterface

interface mrfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/mrfc_alu.sv =====
// shared multi-cycle unit: rounded fixed-point multiply, rounded divide, integer square root
module mrfc_alu
  import mrfc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  localparam int CW = 7;

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_SQRT} astate_t;

  astate_t     st;
  logic [CW-1:0] cnt;
  logic        neg;
  logic [63:0] acc;     // multiply product, division remainder, sqrt remainder
  logic [63:0] opa;     // dividend bits / radicand / multiplicand
  logic [63:0] opb;     // divisor / multiplier
  logic [63:0] quo;     // quotient or root
  logic [63:0] mb;      // full product after both multiply passes
  logic        dfault;

  logic [63:0] rem_sh;
  logic [63:0] sq_try;
  logic [63:0] rnd;
  logic [63:0] mag_r;

  logic [31:0] mhalf;
  logic [63:0] pp;
  logic        mul_ovf;
  logic        div_ovf;
  logic signed [63:0] mul_res;
  logic signed [63:0] div_res;

  // result with sign; overflow if magnitude exceeds 2^31, or signed result out of range
  function automatic logic signed [63:0] signed_fit(input logic [63:0] m, input logic n,
                                                    output logic f);
    logic signed [63:0] v;
    begin
      f = 1'b0;
      v = 64'sd0;
      if (m > 64'h8000_0000) begin
        f = 1'b1;
      end else begin
        v = n ? -$signed(m) : $signed(m);
        if (!fits32(v)) f = 1'b1;
      end
      return f ? 64'sd0 : v;
    end
  endfunction

  always_comb begin
    rem_sh = {acc[62:0], opa[63]};
    sq_try = {quo[61:0], 2'b01};
    mhalf = cnt[0] ? opb[63:32] : opb[31:0];
    pp = {32'd0, opa[31:0]} * {32'd0, mhalf};
    mb = acc + (pp << 32);
    rnd = (mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    // round to nearest: compare remainder against divisor/2
    mag_r = quo + ((acc >= (opb - (opb >> 1))) ? 64'd1 : 64'd0);
    mul_res = signed_fit(rnd, neg, mul_ovf);
    div_res = signed_fit(mag_r, neg, div_ovf);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= A_IDLE;
      rsp <= '0;
      cnt <= '0;
    end else begin
      case (st)
        A_IDLE: begin
          rsp.done <= 1'b0;
          if (req.start) begin
            neg <= req.a[63] ^ req.b[63];
            cnt <= '0;
            acc <= '0;
            quo <= '0;
            dfault <= 1'b0;
            case (req.op)
              OP_MUL: begin
                opa <= mag64(req.a);
                opb <= mag64(req.b);
                st <= A_MUL;
              end
              OP_DIV: begin
                opa <= mag64(req.a) << FRAC_BITS;
                opb <= mag64(req.b);
                dfault <= (req.b == 64'sd0);
                st <= A_DIV;
              end
              OP_SQRT: begin
                opa <= 64'(req.a) << FRAC_BITS;
                st <= A_SQRT;
              end
              default: st <= A_IDLE;
            endcase
          end
        end
        A_MUL: begin
          // operands are 32-bit magnitudes (at most 2^31): two 32x32 passes
          if (cnt == CW'(0)) begin
            acc <= pp;
            cnt <= CW'(1);
            rsp.done <= 1'b0;
          end else begin
            rsp.res <= mul_res;
            rsp.fault <= mul_ovf;
            rsp.done <= 1'b1;
            st <= A_IDLE;
          end
        end
        A_DIV: begin
          if (dfault) begin
            rsp.res <= '0;
            rsp.fault <= 1'b1;
            rsp.done <= 1'b1;
            st <= A_IDLE;
          end else if (cnt == CW'(64)) begin
            rsp.res <= div_res;
            rsp.fault <= div_ovf;
            rsp.done <= 1'b1;
            st <= A_IDLE;
          end else begin
            if (rem_sh >= opb || acc[63]) begin
              acc <= rem_sh - opb;
              quo <= {quo[62:0], 1'b1};
            end else begin
              acc <= rem_sh;
              quo <= {quo[62:0], 1'b0};
            end
            opa <= {opa[62:0], 1'b0};
            cnt <= cnt + CW'(1);
            rsp.done <= 1'b0;
          end
        end
        A_SQRT: begin
          if (cnt == CW'(32)) begin
            rsp.res <= $signed(quo);
            rsp.fault <= 1'b0;
            rsp.done <= 1'b1;
            st <= A_IDLE;
          end else begin
            // two radicand bits per step
            if ({acc[61:0], opa[63:62]} >= sq_try) begin
              acc <= {acc[61:0], opa[63:62]} - sq_try;
              quo <= {quo[62:0], 1'b1};
            end else begin
              acc <= {acc[61:0], opa[63:62]};
              quo <= {quo[62:0], 1'b0};
            end
            opa <= {opa[61:0], 2'b00};
            cnt <= cnt + CW'(1);
            rsp.done <= 1'b0;
          end
        end
        default: begin
          rsp.done <= 1'b0;
          st <= A_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/muller_root_finder_cubic.sv =====
// top level: muller iteration sequencer for x^3 - 2x^2 - 5 around a shared arithmetic unit
//
// Usage: an item on in carries three starting points guess_a, guess_b, guess_c in
// signed fixed point with FRAC_BITS fraction bits. The block answers with one item on
// out: root_value, iterations_used and outcome (converged, limit reached, negative
// discriminant, or divide by zero/overflow).
// cfg writes step_tolerance (index 0) and iteration_limit (index 1); write only when idle.
// in.ready is high only in the idle state; one item is worked on at a time.
// Every multiply, divide and square root passes through one shared unit; a cubic is two
// multiplies and a combine. The setup costs three cubics and three divides, and each
// completed iteration three multiplies, a square root and a divide, then a refit of one
// cubic and three divides.
// The result is held in an output register until out.ready takes it; meanwhile no new
// item is accepted.
// Reset (rst, synchronous) returns to idle, drops out.valid and restores
// step_tolerance = 105 and iteration_limit = 50.
module muller_root_finder_cubic
  import mrfc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  mrfc_in_if.sink    in,
  mrfc_out_if.source out,
  mrfc_cfg_if.sink   cfg
);

  typedef logic signed [63:0] w_t;

  state_t st, st_next;
  state_t ret;          // state to go on from after a cubic or a unit call
  logic [TOL_W-1:0] step_tolerance;
  logic [ITER_W-1:0] iteration_limit;
  logic [ITER_W-1:0] cnt;
  logic fault;
  logic [1:0] sub;      // sub-step within some states
  logic in_iter;

  w_t p0, p1, p2, h1, h2, q1, q2, d, f0, f1, f2, b, g, t, x2, cx, cub;
  w_t hh;

  alu_req_t req;
  alu_rsp_t rsp;

  mrfc_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp)
  );

  assign cfg.ready = 1'b1;
  assign in.ready = (st == S_IDLE) && !out.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_tolerance <= STEP_TOL_RESET;
      iteration_limit <= ITER_LIMIT_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_STEP_TOL) step_tolerance <= cfg.data[TOL_W-1:0];
      else iteration_limit <= cfg.data[ITER_W-1:0];
    end
  end

  function automatic w_t chk(input w_t v, inout logic f);
    if (!fits32(v)) begin
      f = 1'b1;
      return 64'sd0;
    end
    return v;
  endfunction

  // request helper
  function automatic alu_req_t mk(input alu_op_t op, input w_t a, input w_t bb);
    alu_req_t r;
    r.start = 1'b1;
    r.op = op;
    r.a = a;
    r.b = bb;
    return r;
  endfunction

  logic [63:0] mbmg, mbpg;
  logic step_small;
  always_comb begin
    mbmg = mag64(b - g);
    mbpg = mag64(b + g);
    step_small = mag64(hh) < {33'd0, step_tolerance};
  end

  always_comb begin
    st_next = st;
    case (st)
      S_IDLE: begin
        if (in.valid && in.ready) st_next = S_CUB_X2;
      end
      S_CUB_X2, S_CUB_X3: st_next = S_WAIT_ALU;
      S_CUB_SUM: st_next = ret;
      S_WAIT_ALU: begin
        if (rsp.done) begin
          case (sub)
            2'd0: st_next = S_CUB_X3;
            2'd1: st_next = S_CUB_SUM;
            default: st_next = ret;
          endcase
        end
      end
      S_F0, S_F1: st_next = S_CUB_X2;
      S_F2: st_next = S_H;
      S_H, S_Q1, S_Q2: st_next = S_WAIT_ALU;
      S_D: st_next = fault ? S_DONE : S_IT_HD;
      S_IT_HD: st_next = (cnt >= iteration_limit) ? S_DONE : S_WAIT_ALU;
      S_IT_B, S_IT_BB: st_next = S_WAIT_ALU;
      S_IT_FD: st_next = S_IT_DISC;
      S_IT_DISC: st_next = (fault || g < 0) ? S_DONE : S_WAIT_ALU;
      S_IT_SQRT: st_next = S_IT_E;
      S_IT_E: st_next = S_WAIT_ALU;
      S_IT_STEP: st_next = S_IT_CHECK;
      S_IT_CHECK: st_next = (fault || step_small) ? S_DONE : S_CUB_X2;
      S_DONE: st_next = S_IDLE;
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= S_IDLE;
    else st <= st_next;
  end

  // datapath registers; the unit is called through S_WAIT_ALU
  always_ff @(posedge clk) begin
    logic fl;
    w_t v;
    alu_req_t nreq;
    if (rst) begin
      out.valid <= 1'b0;
      req <= '0;
      sub <= '0;
    end else begin
      fl = fault;
      v = 64'sd0;
      nreq = '0;
      if (st == S_DONE) out.valid <= 1'b1;
      else if (out.valid && out.ready) out.valid <= 1'b0;
      case (st)
        S_IDLE: begin
          if (in.valid && in.ready) begin
            p0 <= 64'(in.guess_a);
            p1 <= 64'(in.guess_b);
            p2 <= 64'(in.guess_c);
            cnt <= ITER_START;
            fl = 1'b0;
            in_iter <= 1'b0;
            cx <= 64'(in.guess_a);
            ret <= S_F0;
          end
        end
        // cubic(cx) -> cub, then go to ret
        S_CUB_X2: begin
          nreq = mk(OP_MUL, cx, cx);
          sub <= 2'd0;
        end
        S_CUB_X3: begin
          nreq = mk(OP_MUL, x2, cx);
          sub <= 2'd1;
        end
        S_CUB_SUM: begin
          cub <= chk(t - 2 * x2 - (64'sd5 <<< FRAC_BITS), fl);
        end
        S_WAIT_ALU: begin
          if (rsp.done) begin
            fl = fl | rsp.fault;
            case (sub)
              2'd0: x2 <= rsp.res;
              default: t <= rsp.res;
            endcase
          end
        end
        S_F0: begin
          f0 <= cub;
          cx <= p1; ret <= S_F1;
        end
        S_F1: begin
          f1 <= cub;
          cx <= p2; ret <= S_F2;
        end
        S_F2: begin
          f2 <= cub;
        end
        S_H: begin
          v = chk(p1 - p0, fl);
          h1 <= v;
          h2 <= chk(p2 - p1, fl);
          nreq = mk(OP_DIV, chk(f1 - f0, fl), v);
          sub <= 2'd2; ret <= S_Q1;
        end
        S_Q1: begin
          q1 <= t;
          nreq = mk(OP_DIV, chk(f2 - f1, fl), h2);
          sub <= 2'd2; ret <= S_Q2;
        end
        S_Q2: begin
          q2 <= t;
          v = chk(t - q1, fl);
          nreq = mk(OP_DIV, v, chk(h2 + h1, fl));
          sub <= 2'd2; ret <= S_D;
        end
        S_D: begin
          d <= t;
          if (fl) begin
            out.root_value <= p2[31:0];
            out.iterations_used <= cnt;
            out.outcome <= OUT_FAULT;
          end else begin
            if (in_iter) cnt <= cnt + 8'd1;
            in_iter <= 1'b1;
          end
        end
        S_IT_HD: begin
          if (cnt >= iteration_limit) begin
            out.root_value <= p2[31:0];
            out.iterations_used <= cnt;
            out.outcome <= OUT_LIMIT;
          end else begin
            // f2 already holds cubic(p2)
            nreq = mk(OP_MUL, h2, d);
            sub <= 2'd2; ret <= S_IT_B;
          end
        end
        S_IT_B: begin
          v = chk(q2 + t, fl);
          b <= v;
          nreq = mk(OP_MUL, v, v);
          sub <= 2'd2; ret <= S_IT_BB;
        end
        S_IT_BB: begin
          hh <= t;
          nreq = mk(OP_MUL, f2, d);
          sub <= 2'd2; ret <= S_IT_FD;
        end
        S_IT_FD: begin
          g <= chk(hh - chk(4 * t, fl), fl);
        end
        S_IT_DISC: begin
          if (fl) begin
            out.root_value <= p2[31:0];
            out.iterations_used <= cnt;
            out.outcome <= OUT_FAULT;
          end else if (g < 0) begin
            out.root_value <= p2[31:0];
            out.iterations_used <= cnt;
            out.outcome <= OUT_NEG_DISC;
          end else begin
            nreq = mk(OP_SQRT, g, 64'sd0);
            sub <= 2'd2; ret <= S_IT_SQRT;
          end
        end
        S_IT_SQRT: begin
          g <= t;
        end
        S_IT_E: begin
          if (mbmg < mbpg) v = chk(b + g, fl);
          else v = chk(b - g, fl);
          nreq = mk(OP_DIV, chk(-2 * f2, fl), v);
          sub <= 2'd2; ret <= S_IT_STEP;
        end
        S_IT_STEP: begin
          hh <= t;
          cx <= chk(p2 + t, fl);
        end
        S_IT_CHECK: begin
          if (fl) begin
            out.root_value <= p2[31:0];
            out.iterations_used <= cnt;
            out.outcome <= OUT_FAULT;
          end else if (step_small) begin
            out.root_value <= cx[31:0];
            out.iterations_used <= cnt;
            out.outcome <= OUT_CONVERGED;
          end else begin
            p0 <= p1; p1 <= p2; p2 <= cx;
            f0 <= f1; f1 <= f2;
            ret <= S_F2;
          end
        end
        default: begin
        end
      endcase
      req <= nreq;
      fault <= fl;
    end
  end

  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> st == S_IDLE || st_next == S_IDLE)
    else $error("result shown while busy");
  a_count: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> out.iterations_used >= ITER_START)
    else $error("iteration count below start");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (st != S_IDLE) |-> !in.ready)
    else $error("input ready while busy");

endmodule

// ===== bench/muller_root_finder_cubic_tb.sv =====
// testbench for the muller cubic root finder: random and directed items checked against a predictor
module muller_root_finder_cubic_tb;
  import mrfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = FRAC_BITS_DEF;
  localparam int ROOT_Q = 2821522;  // about 2.6908, near the real root

  typedef struct {
    logic signed [31:0] root;
    logic [7:0]         iters;
    outcome_t           outcome;
  } root_result_t;

  class root_scoreboard;
    longint unsigned tol_reg;
    longint unsigned limit_reg;
    bit              ovf;
    root_result_t    pending[$];
    int              errors;

    function new();
      tol_reg = STEP_TOL_RESET;
      limit_reg = ITER_LIMIT_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [31:0] data);
      if (idx == REG_STEP_TOL) tol_reg = data[30:0];
      else limit_reg = data[7:0];
    endfunction

    function longint fit(longint v);
      if (v > 64'sd2147483647 || v < -64'sd2147483648) begin
        ovf = 1;
        return 0;
      end
      return v;
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function longint signed_of(longint unsigned m, bit neg);
      if (m > 64'h8000_0000) begin
        ovf = 1;
        return 0;
      end
      return neg ? -longint'(m) : longint'(m);
    endfunction

    function longint fx_mul(longint a, longint b);
      longint unsigned m;
      m = (mag(a) * mag(b) + (64'd1 << (FB - 1))) >> FB;
      return fit(signed_of(m, (a < 0) != (b < 0)));
    endfunction

    function longint fx_div(longint a, longint b);
      longint unsigned num, den;
      if (b == 0) begin
        ovf = 1;
        return 0;
      end
      num = mag(a) << FB;
      den = mag(b);
      return fit(signed_of((num + den / 2) / den, (a < 0) != (b < 0)));
    endfunction

    function longint fx_sqrt(longint v);
      longint unsigned n, res, bitv;
      n = 64'(v) << FB;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else res >>= 1;
        bitv >>= 2;
      end
      return longint'(res);
    endfunction

    function longint poly(longint x);
      longint x2, x3;
      x2 = fx_mul(x, x);
      x3 = fx_mul(x2, x);
      return fit(x3 - 2 * x2 - (64'sd5 << FB));
    endfunction

    function root_result_t pack_result(longint r, longint unsigned n, outcome_t oc);
      root_result_t res;
      res.root = r[31:0];
      res.iters = n[7:0];
      res.outcome = oc;
      return res;
    endfunction

    function root_result_t predict(longint p0, longint p1, longint p2);
      longint h1, h2, q1, q2, d, f2, b, disc, g, e, h, p;
      longint unsigned n;
      n = 3;
      ovf = 0;
      h1 = fit(p1 - p0);
      h2 = fit(p2 - p1);
      q1 = fx_div(fit(poly(p1) - poly(p0)), h1);
      q2 = fx_div(fit(poly(p2) - poly(p1)), h2);
      d = fx_div(fit(q2 - q1), fit(h2 + h1));
      if (ovf) return pack_result(p2, 3, OUT_FAULT);
      while (n < limit_reg) begin
        f2 = poly(p2);
        b = fit(q2 + fx_mul(h2, d));
        disc = fit(fx_mul(b, b) - fit(4 * fx_mul(f2, d)));
        if (ovf) return pack_result(p2, n, OUT_FAULT);
        if (disc < 0) return pack_result(p2, n, OUT_NEG_DISC);
        g = fx_sqrt(disc);
        if (mag(b - g) < mag(b + g)) e = fit(b + g);
        else e = fit(b - g);
        h = fx_div(fit(-2 * f2), e);
        p = fit(p2 + h);
        if (ovf) return pack_result(p2, n, OUT_FAULT);
        if (mag(h) < tol_reg) return pack_result(p, n, OUT_CONVERGED);
        p0 = p1;
        p1 = p2;
        p2 = p;
        h1 = fit(p1 - p0);
        h2 = fit(p2 - p1);
        q1 = fx_div(fit(poly(p1) - poly(p0)), h1);
        q2 = fx_div(fit(poly(p2) - poly(p1)), h2);
        d = fx_div(fit(q2 - q1), fit(h2 + h1));
        if (ovf) return pack_result(p2, n, OUT_FAULT);
        n++;
      end
      return pack_result(p2, n, OUT_LIMIT);
    endfunction

    function void note_item(logic signed [31:0] a, logic signed [31:0] b,
                            logic signed [31:0] c);
      pending.push_back(predict(a, b, c));
    endfunction

    function void check_result(logic signed [31:0] root, logic [7:0] iters,
                               logic [1:0] oc);
      root_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected item root=%0d iters=%0d outcome=%0d",
                 $time, root, iters, oc);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (root !== want.root) begin
        $display("%0t: root_value expected %0d actual %0d", $time, want.root, root);
        errors++;
      end
      if (iters !== want.iters) begin
        $display("%0t: iterations_used expected %0d actual %0d", $time, want.iters, iters);
        errors++;
      end
      if (oc !== want.outcome) begin
        $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, oc);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  int   src_idle = 31;
  int   snk_idle = 54;
  logic stall_on = 0;

  mrfc_in_if  in_if();
  mrfc_out_if out_if();
  mrfc_cfg_if cfg_if();

  root_scoreboard sb = new();

  muller_root_finder_cubic dut (
    .clk(clk),
    .rst(rst),
    .in(in_if),
    .out(out_if),
    .cfg(cfg_if)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    in_if.valid = 0;
    in_if.guess_a = 0;
    in_if.guess_b = 0;
    in_if.guess_c = 0;
    out_if.ready = 0;
    cfg_if.valid = 0;
    cfg_if.index = REG_STEP_TOL;
    cfg_if.data = 0;
  end

  always @(posedge clk) begin
    if (rst || stall_on) out_if.ready <= 0;
    else out_if.ready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready)
      sb.check_result(out_if.root_value, out_if.iterations_used, out_if.outcome);
  end

  task automatic send_item(int a, int b, int c);
    in_if.valid <= 1;
    in_if.guess_a <= a;
    in_if.guess_b <= b;
    in_if.guess_c <= c;
    do @(posedge clk); while (!in_if.ready);
    sb.note_item(a, b, c);
    if ($urandom_range(99) < src_idle) begin
      in_if.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] data);
    cfg_if.valid <= 1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, data);
  endtask

  task automatic drain();
    in_if.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] tol, logic [31:0] lim);
    drain();
    write_reg(REG_STEP_TOL, tol);
    write_reg(REG_ITER_LIMIT, lim);
    cfg_if.valid <= 0;
    @(posedge clk);
  endtask

  // mostly points scattered around the real root, some full-range noise
  task automatic send_random();
    int a, b, c;
    if ($urandom_range(99) < 20) begin
      a = $urandom;
      b = $urandom;
      c = $urandom;
    end else begin
      a = ROOT_Q + int'($urandom_range(0, 8 << FB)) - (4 << FB);
      b = ROOT_Q + int'($urandom_range(0, 8 << FB)) - (4 << FB);
      c = ROOT_Q + int'($urandom_range(0, 2 << FB)) - (1 << FB);
    end
    send_item(a, b, c);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset settings
    send_item(1 << FB, 2 << FB, 3 << FB);
    send_item(-(1 << FB), 0, 1 << FB);
    send_item(32'sh8000_0000, 32'sh7fff_ffff, 0);
    send_item(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    send_item(5 << FB, 5 << FB, 6 << FB);
    send_item(0, 0, 0);
    send_item(1 << FB, 2 << FB, 1 << FB);
    send_item(-(3 << FB), -(2 << FB), -(1 << FB));
    send_item(-(100 << FB), 50 << FB, 10 << FB);
    send_item(ROOT_Q - 1000, ROOT_Q + 1000, ROOT_Q);
    send_item(ROOT_Q, ROOT_Q + 1, ROOT_Q + 2);
    send_item(-1, 1, 32'sh7fff_ffff);

    set_regs(0, 3);
    send_item(1 << FB, 2 << FB, 3 << FB);
    send_item(0, 0, 0);
    send_item(32'sh8000_0000, 0, 32'sh7fff_ffff);

    set_regs(32'h7fff_ffff, 255);
    send_item(1 << FB, 2 << FB, 3 << FB);
    send_item(-(1 << FB), 0, 1 << FB);
    send_item(10 << FB, 20 << FB, 30 << FB);

    set_regs(0, 12);
    send_item(1 << FB, 2 << FB, 3 << FB);
    send_item(ROOT_Q - 5000, ROOT_Q + 7000, ROOT_Q + 3);

    set_regs(1, 255);
    send_item(2 << FB, 3 << FB, ROOT_Q);

    for (int seg = 0; seg < 4; seg++) begin
      if ($urandom_range(3) == 0) set_regs($urandom & 32'h7fff_ffff, $urandom_range(3, 40));
      else set_regs($urandom_range(0, 2000), $urandom_range(3, 40));
      if (seg >= 2) begin
        src_idle = (seg == 2) ? 54 : 0;
        snk_idle = (seg == 2) ? 31 : 0;
      end
      if (seg == 1) begin
        fork
          begin
            stall_on <= 1;
            repeat (3000) @(posedge clk);
            stall_on <= 0;
          end
        join_none
      end
      repeat (25) send_random();
    end

    in_if.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #400_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mrfc_pkg.sv
rtl/mrfc_if.sv
rtl/mrfc_alu.sv
rtl/muller_root_finder_cubic.sv
bench/muller_root_finder_cubic_tb.sv
